>>> rtl/core/climb_tone_interpolator_assert.svh
// Assertion macros used by the checker file of the tone interpolator.
`ifndef CLIMB_TONE_INTERPOLATOR_ASSERT_SVH
`define CLIMB_TONE_INTERPOLATOR_ASSERT_SVH

// Checks that a condition implies a consequence in the same cycle.
`define CTI_ASSERT_IMP(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("assertion failed");

// Checks that a condition implies a consequence in the next cycle.
`define CTI_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/core/cti_pkg.sv
// Package with the constants and types of the tone interpolator.
package cti_pkg;

  localparam int MaxCurves = 8;
  localparam int MaxPoints = 16;
  localparam int CurveW = $clog2(MaxCurves);
  localparam int PointW = $clog2(MaxPoints);
  localparam int AddrW = CurveW + PointW;
  localparam int CountW = $clog2(MaxPoints + 1);
  localparam int TonesW = 4;
  localparam int NumW = 34;
  localparam logic signed [15:0] ClimbLimit = 16'sd1000;
  localparam logic [6:0] PacketModulus = 7'd100;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_COUNT = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef struct packed {
    logic signed [15:0] climb;
    logic signed [15:0] freq;
    logic signed [15:0] dura;
  } bp_t;

endpackage

>>> rtl/core/climb_tone_interpolator.sv
// Top level of the piecewise linear tone interpolator.
// A write or count action is taken while idle; busy stays low. A query with
// curves in use raises busy and walks them one after another: each curve costs
// its point scan through the breakpoint memory (one point a cycle, then the
// read latency drained), two reads of the bracketing points and a latch
// state, and, when both bracketing points are found, differ and span a
// positive climb, two serial divisions (frequency, then duration) through one
// shared restoring divider, each made of a load, 34 shift-subtract steps and
// a result step. The result is then emitted, and the sequencer moves to the
// next curve. Each result is shown for exactly one cycle with out_valid high
// and cannot be held off by the receiver; the query's last result carries
// out_last. A query with no curve in use gives no result but still advances
// the packet number, which is 1 for the first query and wraps at 100.
module climb_tone_interpolator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_action,
  input  logic [2:0]         in_curve_sel,
  input  logic [3:0]         in_point_sel,
  input  logic signed [15:0] in_point_climb,
  input  logic signed [15:0] in_point_freq,
  input  logic signed [15:0] in_point_dura,
  input  logic [4:0]         in_point_count,
  input  logic signed [15:0] in_climb_value,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_wdata,
  output logic               out_valid,
  output logic [2:0]         out_curve_index,
  output logic               out_hit,
  output logic signed [15:0] out_tone_freq,
  output logic signed [15:0] out_tone_dura,
  output logic [6:0]         out_packet_number,
  output logic               out_last
);

  // Sequencer states, one-hot.
  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_SCAN  = 9'b000000010,
    ST_RDP   = 9'b000000100,
    ST_RDN   = 9'b000001000,
    ST_LATCH = 9'b000010000,
    ST_DIVF  = 9'b000100000,
    ST_DIVD  = 9'b001000000,
    ST_EMIT  = 9'b010000000,
    ST_NEXTC = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // Breakpoint memory: one write port, one registered read port.
  cti_pkg::bp_t mem [cti_pkg::MaxCurves * cti_pkg::MaxPoints];
  logic [cti_pkg::AddrW-1:0] rd_addr;
  logic rd_en;
  cti_pkg::bp_t rd_q_r;

  logic [cti_pkg::CountW-1:0] len_r [cti_pkg::MaxCurves];
  logic [cti_pkg::TonesW-1:0] tones_r;
  logic [6:0] pkt_r;

  logic signed [15:0] climb_r;
  logic [cti_pkg::CurveW:0] ncurves_r;
  logic [cti_pkg::CurveW-1:0] curve_r;
  logic [cti_pkg::CountW-1:0] idx_r;      // address issued
  logic                       chk_r;      // read data valid for point chk_idx_r
  logic [cti_pkg::PointW-1:0] chk_idx_r;
  logic                       have_prev_r, have_next_r;
  logic [cti_pkg::PointW-1:0] prev_r, next_r;
  cti_pkg::bp_t p_r, n_r;

  // Divider state.
  logic [cti_pkg::NumW-1:0]  rem_r;    // magnitude of numerator being shifted out
  logic [cti_pkg::NumW-1:0]  quo_r;
  logic [cti_pkg::NumW-1:0]  acc_r;
  logic [16:0]      span_r;
  logic [5:0]       dcnt_r;
  logic             neg_r;
  logic signed [15:0] res_f_r, res_d_r;

  logic [cti_pkg::CountW-1:0] cur_len;
  logic signed [16:0] off;
  logic signed [cti_pkg::NumW-1:0] num_f, num_d;
  logic [cti_pkg::NumW-1:0] acc_sh;
  logic [cti_pkg::NumW:0]   acc_sub;

  assign cur_len = len_r[curve_r];
  assign off = 17'(climb_r) - 17'(p_r.climb);

  // Numerator pv*span + off*(nv-pv); operands are sign-extended first so that
  // both products keep their full width, and the sum stays under 34 bits.
  assign num_f = cti_pkg::NumW'(p_r.freq) * $signed(cti_pkg::NumW'(span_r))
               + cti_pkg::NumW'(off)
                 * (cti_pkg::NumW'(n_r.freq) - cti_pkg::NumW'(p_r.freq));
  assign num_d = cti_pkg::NumW'(p_r.dura) * $signed(cti_pkg::NumW'(span_r))
               + cti_pkg::NumW'(off)
                 * (cti_pkg::NumW'(n_r.dura) - cti_pkg::NumW'(p_r.dura));

  assign acc_sh  = {acc_r[cti_pkg::NumW-2:0], rem_r[cti_pkg::NumW-1]};
  assign acc_sub = {1'b0, acc_sh} - (cti_pkg::NumW+1)'(span_r);

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    rd_en = 1'b0;
    rd_addr = {curve_r, idx_r[cti_pkg::PointW-1:0]};
    if (state_r == ST_SCAN) begin
      rd_en = !have_next_r && (idx_r < cur_len);
    end else if (state_r == ST_RDP) begin
      rd_en = 1'b1;
      rd_addr = {curve_r, prev_r};
    end else if (state_r == ST_RDN) begin
      rd_en = 1'b1;
      rd_addr = {curve_r, next_r};
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy && in_action == cti_pkg::ACT_WRITE) begin
      mem[{in_curve_sel, in_point_sel}] <= '{in_point_climb, in_point_freq, in_point_dura};
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start && in_action == cti_pkg::ACT_QUERY) begin
          state_nxt = (tones_r == '0) ? ST_IDLE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!rd_en && !chk_r) state_nxt = ST_RDP;
      end
      ST_RDP:   state_nxt = ST_RDN;
      ST_RDN:   state_nxt = ST_LATCH;
      ST_LATCH: state_nxt = ST_DIVF;
      ST_DIVF:  state_nxt = ST_DIVF;
      ST_DIVD:  state_nxt = ST_DIVD;
      ST_EMIT:  state_nxt = ST_NEXTC;
      ST_NEXTC: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  logic signed [15:0] cl_in;
  always_comb begin
    cl_in = in_climb_value;
    if (in_climb_value > cti_pkg::ClimbLimit) cl_in = cti_pkg::ClimbLimit;
    else if (in_climb_value < -cti_pkg::ClimbLimit) cl_in = -cti_pkg::ClimbLimit;
  end

  logic [cti_pkg::CountW-1:0] cnt_sat;
  assign cnt_sat = (in_point_count > 5'(cti_pkg::MaxPoints))
                 ? cti_pkg::CountW'(cti_pkg::MaxPoints) : in_point_count;

  logic [cti_pkg::NumW-1:0] mag_f;
  assign mag_f = num_f[cti_pkg::NumW-1] ? cti_pkg::NumW'(-num_f) : cti_pkg::NumW'(num_f);
  logic [cti_pkg::NumW-1:0] mag_d;
  assign mag_d = num_d[cti_pkg::NumW-1] ? cti_pkg::NumW'(-num_d) : cti_pkg::NumW'(num_d);
  logic same;
  assign same = !have_prev_r || !have_next_r || (prev_r == next_r)
              || ($signed(span_r) <= 0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tones_r <= '0;
      pkt_r <= '0;
      out_valid <= 1'b0;
      chk_r <= 1'b0;
      for (int i = 0; i < cti_pkg::MaxCurves; i++) len_r[i] <= '0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_we) tones_r <= cfg_wdata;
      case (state_r)
        ST_IDLE: begin
          if (start && in_action == cti_pkg::ACT_COUNT) begin
            len_r[in_curve_sel] <= cnt_sat;
          end
          if (start && in_action == cti_pkg::ACT_QUERY) begin
            pkt_r <= (pkt_r == cti_pkg::PacketModulus - 7'd1) ? 7'd0 : pkt_r + 7'd1;
            climb_r <= cl_in;
            ncurves_r <= (tones_r > cti_pkg::TonesW'(cti_pkg::MaxCurves))
                       ? (cti_pkg::CurveW+1)'(cti_pkg::MaxCurves)
                       : (cti_pkg::CurveW+1)'(tones_r);
            curve_r <= '0;
            idx_r <= '0;
            chk_r <= 1'b0;
            have_prev_r <= 1'b0;
            have_next_r <= 1'b0;
            prev_r <= '0;
            next_r <= '0;
          end
          state_r <= state_nxt;
        end
        ST_SCAN: begin
          chk_r <= rd_en;
          chk_idx_r <= idx_r[cti_pkg::PointW-1:0];
          if (rd_en) idx_r <= idx_r + 1'b1;
          if (chk_r && !have_next_r) begin
            if (rd_q_r.climb <= climb_r) begin
              prev_r <= chk_idx_r;
              have_prev_r <= 1'b1;
            end
            if (rd_q_r.climb >= climb_r) begin
              next_r <= chk_idx_r;
              have_next_r <= 1'b1;
            end
          end
          if (state_nxt == ST_RDP) chk_r <= 1'b0;
          state_r <= state_nxt;
        end
        ST_RDP: state_r <= ST_RDN;
        ST_RDN: begin
          p_r <= rd_q_r;
          state_r <= ST_LATCH;
        end
        ST_LATCH: begin
          n_r <= rd_q_r;
          span_r <= 17'(rd_q_r.climb) - 17'(p_r.climb);
          state_r <= ST_DIVF;
          dcnt_r <= '0;
        end
        ST_DIVF, ST_DIVD: begin
          if (same) begin
            res_f_r <= have_prev_r && have_next_r ? p_r.freq : 16'sd0;
            res_d_r <= have_prev_r && have_next_r ? p_r.dura : 16'sd0;
            state_r <= ST_EMIT;
          end else if (dcnt_r == 6'd0) begin
            rem_r <= (state_r == ST_DIVF) ? mag_f : mag_d;
            neg_r <= (state_r == ST_DIVF) ? num_f[cti_pkg::NumW-1] : num_d[cti_pkg::NumW-1];
            acc_r <= '0;
            quo_r <= '0;
            dcnt_r <= 6'd1;
          end else if (dcnt_r <= 6'(cti_pkg::NumW)) begin
            rem_r <= {rem_r[cti_pkg::NumW-2:0], 1'b0};
            if (!acc_sub[cti_pkg::NumW]) begin
              acc_r <= acc_sub[cti_pkg::NumW-1:0];
              quo_r <= {quo_r[cti_pkg::NumW-2:0], 1'b1};
            end else begin
              acc_r <= acc_sh;
              quo_r <= {quo_r[cti_pkg::NumW-2:0], 1'b0};
            end
            dcnt_r <= dcnt_r + 6'd1;
          end else begin
            dcnt_r <= '0;
            if (state_r == ST_DIVF) begin
              res_f_r <= neg_r ? 16'(-quo_r) : quo_r[15:0];
              state_r <= ST_DIVD;
            end else begin
              res_d_r <= neg_r ? 16'(-quo_r) : quo_r[15:0];
              state_r <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          out_valid <= 1'b1;
          out_curve_index <= curve_r;
          out_hit <= have_prev_r && have_next_r;
          out_tone_freq <= res_f_r;
          out_tone_dura <= res_d_r;
          out_packet_number <= pkt_r;
          out_last <= ((cti_pkg::CurveW+1)'(curve_r) + 1'b1 == ncurves_r);
          state_r <= ST_NEXTC;
        end
        ST_NEXTC: begin
          idx_r <= '0;
          have_prev_r <= 1'b0;
          have_next_r <= 1'b0;
          prev_r <= '0;
          next_r <= '0;
          if ((cti_pkg::CurveW+1)'(curve_r) + 1'b1 == ncurves_r) begin
            state_r <= ST_IDLE;
          end else begin
            curve_r <= curve_r + 1'b1;
            state_r <= ST_SCAN;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/cti_checker.sv
// Port checker for the tone interpolator, with its bind statement.
`include "climb_tone_interpolator_assert.svh"
module cti_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       busy,
  input logic       out_valid,
  input logic       out_last,
  input logic [6:0] out_packet_number
);
  `CTI_ASSERT_IMP(a_valid_busy, clk, rst_n, out_valid && !out_last, busy)
  `CTI_ASSERT_IMP(a_pkt_range, clk, rst_n, out_valid, out_packet_number < 7'd100)
  `CTI_ASSERT_NEXT(a_gap, clk, rst_n, out_valid, !out_valid)
endmodule

bind climb_tone_interpolator cti_checker u_cti_checker (
  .clk(clk), .rst_n(rst_n), .busy(busy), .out_valid(out_valid),
  .out_last(out_last), .out_packet_number(out_packet_number)
);

>>> sim/testbench.sv
// Self-checking testbench for the tone interpolator: directed, random and packet-wrap tests.
`timescale 1ns / 1ps

module testbench;

  // Cycles without any accepted item or result before the run is declared hung.
  localparam int HangLimit = 4000;
  // Settle time that covers the longest query, used before register writes and at the end.
  localparam int SettleCycles = 800;

  // One command to the block. Fields that an action does not use are still driven.
  typedef struct {
    cti_pkg::action_t   act;
    logic [2:0]         curve;
    logic [3:0]         point;
    logic signed [15:0] pt_climb;
    logic signed [15:0] pt_freq;
    logic signed [15:0] pt_dura;
    logic [4:0]         count;
    logic signed [15:0] climb;
  } tone_cmd_t;

  // One tone result as the block should present it.
  typedef struct {
    logic [2:0]         curve;
    logic               hit;
    logic signed [15:0] freq;
    logic signed [15:0] dura;
    logic [6:0]         packet;
    logic               last;
  } tone_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_action = '0;
  logic [2:0]         in_curve_sel = '0;
  logic [3:0]         in_point_sel = '0;
  logic signed [15:0] in_point_climb = '0;
  logic signed [15:0] in_point_freq = '0;
  logic signed [15:0] in_point_dura = '0;
  logic [4:0]         in_point_count = '0;
  logic signed [15:0] in_climb_value = '0;
  logic               cfg_we = 1'b0;
  logic [3:0]         cfg_wdata = '0;
  logic               out_valid;
  logic [2:0]         out_curve_index;
  logic               out_hit;
  logic signed [15:0] out_tone_freq;
  logic signed [15:0] out_tone_dura;
  logic [6:0]         out_packet_number;
  logic               out_last;

  climb_tone_interpolator u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .in_curve_sel      (in_curve_sel),
    .in_point_sel      (in_point_sel),
    .in_point_climb    (in_point_climb),
    .in_point_freq     (in_point_freq),
    .in_point_dura     (in_point_dura),
    .in_point_count    (in_point_count),
    .in_climb_value    (in_climb_value),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_curve_index   (out_curve_index),
    .out_hit           (out_hit),
    .out_tone_freq     (out_tone_freq),
    .out_tone_dura     (out_tone_dura),
    .out_packet_number (out_packet_number),
    .out_last          (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow copy of the block state, kept in step with every accepted item.
  cti_pkg::bp_t curve_points [cti_pkg::MaxCurves][cti_pkg::MaxPoints];
  bit         point_loaded [cti_pkg::MaxCurves][cti_pkg::MaxPoints];
  int         curve_len [cti_pkg::MaxCurves];
  int         packet_count;
  int         tones_reg;

  tone_result_t pending_tones[$];
  int           fail_count;
  int           idle_run;
  int           sender_gap_pct;

  // Number of points from index 0 upward that hold written data. A count is never
  // set beyond it, so a query never reads an entry that was never written.
  function automatic int loaded_prefix(input int c);
    int n;
    n = 0;
    while (n < cti_pkg::MaxPoints && point_loaded[c][n]) n++;
    return n;
  endfunction

  // Linear interpolation between two breakpoint values, truncated toward zero.
  function automatic logic signed [15:0] blend(input longint pv, input longint nv,
                                               input longint off, input longint span);
    longint num;
    num = pv * span + off * (nv - pv);
    return 16'(num / span);
  endfunction

  // Applies one accepted item to the shadow state and queues the tones it must produce.
  task automatic track_item(input tone_cmd_t cmd);
    int           climb, ncurves, cnt, prev_i, next_i, span;
    bit           have_prev, have_next;
    cti_pkg::bp_t p, n;
    tone_result_t r;
    case (cmd.act)
      cti_pkg::ACT_WRITE: begin
        curve_points[cmd.curve][cmd.point] = '{cmd.pt_climb, cmd.pt_freq, cmd.pt_dura};
        point_loaded[cmd.curve][cmd.point] = 1'b1;
      end
      cti_pkg::ACT_COUNT: begin
        cnt = cmd.count;
        curve_len[cmd.curve] = (cnt > cti_pkg::MaxPoints) ? cti_pkg::MaxPoints : cnt;
      end
      cti_pkg::ACT_QUERY: begin
        climb = cmd.climb;
        if (climb > 1000) climb = 1000;
        else if (climb < -1000) climb = -1000;
        packet_count = (packet_count + 1) % 100;
        ncurves = (tones_reg > cti_pkg::MaxCurves) ? cti_pkg::MaxCurves : tones_reg;
        for (int c = 0; c < ncurves; c++) begin
          have_prev = 0;
          have_next = 0;
          prev_i = 0;
          next_i = 0;
          // The scan stops at the first point at or above the climb.
          for (int i = 0; i < curve_len[c]; i++) begin
            if (curve_points[c][i].climb <= climb) begin
              prev_i = i;
              have_prev = 1;
            end
            if (curve_points[c][i].climb >= climb) begin
              next_i = i;
              have_next = 1;
              break;
            end
          end
          r.curve = 3'(c);
          r.hit = have_prev && have_next;
          r.freq = '0;
          r.dura = '0;
          if (r.hit) begin
            p = curve_points[c][prev_i];
            n = curve_points[c][next_i];
            span = int'(n.climb) - int'(p.climb);
            if (prev_i == next_i || span <= 0) begin
              r.freq = p.freq;
              r.dura = p.dura;
            end else begin
              r.freq = blend(p.freq, n.freq, climb - p.climb, span);
              r.dura = blend(p.dura, n.dura, climb - p.climb, span);
            end
          end
          r.packet = 7'(packet_count);
          r.last = (c + 1 == ncurves);
          pending_tones.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  // Drives one item, waits for the block to take it, then updates the shadow state.
  // The sender may first hold start low, depending on the current phase.
  task automatic send_item(input tone_cmd_t cmd);
    if (sender_gap_pct > 0 && $urandom_range(99) < sender_gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start          <= 1'b1;
    in_action      <= cmd.act;
    in_curve_sel   <= cmd.curve;
    in_point_sel   <= cmd.point;
    in_point_climb <= cmd.pt_climb;
    in_point_freq  <= cmd.pt_freq;
    in_point_dura  <= cmd.pt_dura;
    in_point_count <= cmd.count;
    in_climb_value <= cmd.climb;
    do @(posedge clk); while (busy);
    track_item(cmd);
  endtask

  // Random filler for the fields that an action does not look at.
  function automatic tone_cmd_t noise_cmd(input cti_pkg::action_t act);
    tone_cmd_t cmd;
    cmd.act = act;
    cmd.curve = 3'($urandom);
    cmd.point = 4'($urandom);
    cmd.pt_climb = 16'($urandom);
    cmd.pt_freq = 16'($urandom);
    cmd.pt_dura = 16'($urandom);
    cmd.count = 5'($urandom);
    cmd.climb = 16'($urandom);
    return cmd;
  endfunction

  task automatic send_point(input int c, input int p, input int climb, input int freq,
                            input int dura);
    tone_cmd_t cmd;
    cmd = noise_cmd(cti_pkg::ACT_WRITE);
    cmd.curve = 3'(c);
    cmd.point = 4'(p);
    cmd.pt_climb = 16'(climb);
    cmd.pt_freq = 16'(freq);
    cmd.pt_dura = 16'(dura);
    send_item(cmd);
  endtask

  task automatic send_count(input int c, input int cnt);
    tone_cmd_t cmd;
    cmd = noise_cmd(cti_pkg::ACT_COUNT);
    cmd.curve = 3'(c);
    cmd.count = 5'(cnt);
    send_item(cmd);
  endtask

  task automatic send_query(input int climb);
    tone_cmd_t cmd;
    cmd = noise_cmd(cti_pkg::ACT_QUERY);
    cmd.climb = 16'(climb);
    send_item(cmd);
  endtask

  // Lowers start, waits for every queued tone and then for the longest query to end.
  task automatic wait_quiet();
    start <= 1'b0;
    while (pending_tones.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // The register is only written while the block is quiet.
  task automatic set_tones(input int v);
    wait_quiet();
    cfg_we    <= 1'b1;
    cfg_wdata <= 4'(v);
    @(posedge clk);
    cfg_we    <= 1'b0;
    tones_reg = v;
  endtask

  // Hand-picked curves: field extremes, equal climbs, an unsorted curve and empty
  // curves, with queries at both clamps, on points and between them. The register
  // value 15 checks that curves in use saturate at eight.
  task automatic test_directed();
    set_tones(15);
    send_point(0, 0, -1000, 32767, -32768);
    send_point(0, 1, 0, -32768, 32767);
    send_point(0, 2, 1000, 100, 5);
    send_count(0, 3);
    send_point(1, 0, 200, 7, 9);
    send_point(1, 1, 200, 50, -3);
    send_count(1, 2);
    send_point(2, 0, 500, 10, 10);
    send_point(2, 1, -500, 20, 20);
    send_point(2, 2, 0, 30, 30);
    send_count(2, 3);
    send_count(3, 0);
    send_query(32767);
    send_query(-32768);
    send_query(0);
    send_query(200);
    send_query(500);
    send_query(-1);
    send_query(-333);
    send_item(noise_cmd(cti_pkg::ACT_NONE));
    send_query(777);
  endtask

  // Loads a curve with ascending points (equal climbs allowed), sets its count and
  // queries it. A fully loaded curve sometimes gets a count at or above the maximum.
  task automatic load_and_query(inout int sent);
    int c, npts, climb, cnt;
    c = $urandom_range(cti_pkg::MaxCurves - 1);
    npts = ($urandom_range(3) == 0) ? cti_pkg::MaxPoints : $urandom_range(2, 6);
    climb = $urandom_range(2400) - 1200;
    for (int i = 0; i < npts; i++) begin
      send_point(c, i, climb, int'($urandom) - 32'sh8000, int'($urandom) - 32'sh8000);
      climb += $urandom_range(0, 300);
      sent++;
    end
    cnt = npts;
    if (npts == cti_pkg::MaxPoints && $urandom_range(1)) begin
      cnt = $urandom_range(cti_pkg::MaxPoints, 31);
    end else if (npts >= loaded_prefix(c)) begin
      cnt = $urandom_range(1, npts);
    end
    send_count(c, cnt);
    sent++;
    repeat ($urandom_range(1, 3)) begin
      send_query($urandom_range(2400) - 1200);
      sent++;
    end
  endtask

  // Random phase: mostly curve loads followed by queries, plus lone queries and noise.
  task automatic test_random(input int items, input int gap_pct);
    int        sent, pick, c;
    tone_cmd_t cmd;
    sender_gap_pct = gap_pct;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        load_and_query(sent);
      end else if (pick < 80) begin
        cmd = noise_cmd(cti_pkg::ACT_QUERY);
        if ($urandom_range(4) != 0) cmd.climb = 16'($urandom_range(2200) - 1100);
        send_item(cmd);
        sent++;
      end else if (pick < 88) begin
        send_item(noise_cmd(cti_pkg::ACT_WRITE));
        sent++;
      end else if (pick < 95) begin
        c = $urandom_range(cti_pkg::MaxCurves - 1);
        cmd = noise_cmd(cti_pkg::ACT_COUNT);
        cmd.curve = 3'(c);
        if (loaded_prefix(c) < cti_pkg::MaxPoints) begin
          cmd.count = 5'($urandom_range(loaded_prefix(c)));
        end
        send_item(cmd);
        sent++;
      end else begin
        send_item(noise_cmd(cti_pkg::ACT_NONE));
      end
    end
    sender_gap_pct = 0;
  endtask

  // With no curve in use a query gives no tone, so a run of them walks the packet
  // number up to 99 and across its wrap back to 0 cheaply.
  task automatic test_packet_wrap();
    set_tones(0);
    while (packet_count != 99) send_query(int'($urandom) - 32'sh8000);
    repeat (3) send_query(int'($urandom) - 32'sh8000);
    set_tones(1);
    repeat (3) send_query($urandom_range(2000) - 1000);
  endtask

  task automatic cmp_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Every tone is checked at the edge that ends its one valid cycle.
  always @(posedge clk) begin
    tone_result_t want;
    if (rst_n && out_valid) begin
      if (pending_tones.size() == 0) begin
        $error("unexpected tone for curve %0d", out_curve_index);
        fail_count++;
      end else begin
        want = pending_tones.pop_front();
        cmp_field("curve_index", want.curve, out_curve_index);
        cmp_field("hit", want.hit, out_hit);
        cmp_field("tone_freq", want.freq, out_tone_freq);
        cmp_field("tone_dura", want.dura, out_tone_dura);
        cmp_field("packet_number", want.packet, out_packet_number);
        cmp_field("last", want.last, out_last);
      end
    end
  end

  // Hang detection: counts cycles in which neither an item nor a tone moves.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_run <= 0;
    end else if (idle_run >= HangLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  initial begin
    for (int c = 0; c < cti_pkg::MaxCurves; c++) begin
      curve_len[c] = 0;
      for (int p = 0; p < cti_pkg::MaxPoints; p++) begin
        curve_points[c][p] = '0;
        point_loaded[c][p] = 1'b0;
      end
    end
    packet_count = 0;
    tones_reg = 0;
    fail_count = 0;
    idle_run = 0;
    sender_gap_pct = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    set_tones(8);
    test_random(15, 35);
    set_tones(3);
    test_random(15, 72);
    test_packet_wrap();
    set_tones(8);
    test_random(15, 0);

    wait_quiet();
    if (fail_count == 0 && pending_tones.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
